>>> src/lt3d_pkg.sv
// ----------------------------------------------------------------------------
// lt3d_pkg
// Shared widths, types and constants for the 3D LUT color map.
// ----------------------------------------------------------------------------
package lt3d_pkg;

    localparam int GRID_BITS  = 6;
    localparam int GRID_MAX   = (1 << GRID_BITS) - 1;
    localparam int BANK_AW    = 3 * (GRID_BITS - 1);
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int NUM_BANKS  = 8;
    localparam int FR_BITS    = 7;
    localparam int POS_BITS   = GRID_BITS + FR_BITS;
    localparam int ENT_BITS   = 24;
    localparam int IN_DBITS   = 80;
    localparam int OUT_DBITS  = 32;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_FILTER = 1'b1;

    typedef logic [GRID_BITS-1:0] t_grid;
    typedef logic [FR_BITS-1:0]   t_frac;
    typedef logic [BANK_AW-1:0]   t_baddr;
    typedef logic [ENT_BITS-1:0]  t_entry;

    typedef struct packed {
        logic  clamp;
        logic  lo_odd;
        t_frac fr;
    } t_axis;

endpackage

>>> src/lut3d_trilinear_color_map.sv
// ----------------------------------------------------------------------------
// lut3d_trilinear_color_map
// RGBA color grading through a 64x64x64 RGB table, trilinear interpolation.
// ----------------------------------------------------------------------------
// Input stream: tuser = func (0 loads one table entry, 1 maps one pixel).
// A load request writes entry lut_index and gives no result. A pixel request
// gives one result on the output stream: interpolated red, green, blue
// clamped to 0..255, and alpha passed through.
// Throughput: one request per clock while the output is not stalled. A pixel
// result passes the input reg, then the table read, red lerp, green lerp,
// and blue lerp and clamp into the output reg.
// The table is split into eight banks by the parity of each grid index, so
// the eight cell corners of a pixel come from eight different banks in one
// read cycle; every bank has one write and one read port.
// Table contents are undefined after reset until loaded; reset clears only
// the valid bits of the pipeline.
// When the receiver stalls, the whole pipeline holds and s_axis_tready drops
// while the output register is full and not taken.
// ----------------------------------------------------------------------------
module lut3d_trilinear_color_map (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // lut_index[17:0], lut_red, lut_green, lut_blue, pix_red, pix_green,
    // pix_blue, pix_alpha, zero pad
    input  logic [79:0] s_axis_tdata,
    // func
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [31:0] m_axis_tdata
);

    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // stage 1: input register
    logic        r1_vld, r1_func;
    logic [17:0] r1_idx;
    logic [lt3d_pkg::ENT_BITS-1:0] r1_ent;
    logic [7:0]  r1_pix [3];
    logic [7:0]  r1_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= s_axis_tvalid;
        end
        if (en) begin
            r1_func   <= s_axis_tuser;
            r1_idx    <= s_axis_tdata[17:0];
            r1_ent    <= s_axis_tdata[41:18];
            r1_pix[0] <= s_axis_tdata[49:42];
            r1_pix[1] <= s_axis_tdata[57:50];
            r1_pix[2] <= s_axis_tdata[65:58];
            r1_alpha  <= s_axis_tdata[73:66];
        end
    end

    // position decode and bank addressing
    lt3d_pkg::t_axis  ax1 [3];
    logic [4:0]       a_ev [3];
    logic [4:0]       a_od [3];
    lt3d_pkg::t_baddr rd_addr [lt3d_pkg::NUM_BANKS];
    lt3d_pkg::t_baddr wr_addr;
    logic [2:0]       wr_bank;
    logic             wr_go;

    always_comb begin
        logic [lt3d_pkg::POS_BITS-1:0] pos;
        lt3d_pkg::t_grid lo;
        for (int c = 0; c < 3; c++) begin
            pos = (r1_pix[c] == 8'd0) ? '0 :
                  ({r1_pix[c], 5'd0} - lt3d_pkg::POS_BITS'(1));
            lo  = pos[lt3d_pkg::POS_BITS-1:lt3d_pkg::FR_BITS];
            ax1[c].fr     = pos[lt3d_pkg::FR_BITS-1:0];
            ax1[c].lo_odd = lo[0];
            ax1[c].clamp  = (lo == lt3d_pkg::GRID_BITS'(lt3d_pkg::GRID_MAX));
            a_od[c] = lo[5:1];
            a_ev[c] = lo[5:1] + {4'd0, lo[0]};
        end
        for (int k = 0; k < lt3d_pkg::NUM_BANKS; k++) begin
            rd_addr[k] = {(k[2] ? a_od[2] : a_ev[2]),
                          (k[1] ? a_od[1] : a_ev[1]),
                          (k[0] ? a_od[0] : a_ev[0])};
        end
        wr_bank = {r1_idx[12], r1_idx[6], r1_idx[0]};
        wr_addr = {r1_idx[17:13], r1_idx[11:7], r1_idx[5:1]};
        wr_go   = en && r1_vld && (r1_func == lt3d_pkg::FUNC_WRITE);
    end

    // stage 2: banked table read
    lt3d_pkg::t_entry q [lt3d_pkg::NUM_BANKS];

    for (genvar k = 0; k < lt3d_pkg::NUM_BANKS; k++) begin : g_bank
        lt3d_pkg::t_entry mem [lt3d_pkg::BANK_DEPTH];
        always_ff @(posedge i_clk) begin
            if (wr_go && (wr_bank == 3'(k))) begin
                mem[wr_addr] <= r1_ent;
            end
            if (en) begin
                q[k] <= mem[rd_addr[k]];
            end
        end
    end

    logic            r2_vld;
    lt3d_pkg::t_axis r2_ax [3];
    logic [7:0]      r2_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld && (r1_func == lt3d_pkg::FUNC_FILTER);
        end
        if (en) begin
            r2_ax    <= ax1;
            r2_alpha <= r1_alpha;
        end
    end

    // stage 3: lerp along red; m index = {blue corner, green corner}
    logic signed [17:0] n_m [3][4];

    always_comb begin
        logic [2:0] ka, kb;
        logic signed [9:0] va, vb;
        logic signed [8:0] fr;
        for (int j = 0; j < 4; j++) begin
            for (int c = 0; c < 3; c++) begin
                ka = {r2_ax[2].lo_odd ^ (j[1] & !r2_ax[2].clamp),
                      r2_ax[1].lo_odd ^ (j[0] & !r2_ax[1].clamp),
                      r2_ax[0].lo_odd};
                kb = {ka[2:1], r2_ax[0].lo_odd ^ !r2_ax[0].clamp};
                va = {2'b00, q[ka][8*c +: 8]};
                vb = {2'b00, q[kb][8*c +: 8]};
                fr = {2'b00, r2_ax[0].fr};
                n_m[c][j] = 18'(signed'({va, 7'd0})) + 18'((vb - va) * fr);
            end
        end
    end

    logic               r3_vld;
    logic signed [17:0] r3_m [3][4];
    lt3d_pkg::t_frac    r3_fg, r3_fb;
    logic [7:0]         r3_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
        if (en) begin
            r3_m     <= n_m;
            r3_fg    <= r2_ax[1].fr;
            r3_fb    <= r2_ax[2].fr;
            r3_alpha <= r2_alpha;
        end
    end

    // stage 4: lerp along green
    logic signed [17:0] n_n [3][2];

    always_comb begin
        logic signed [18:0] d;
        logic signed [27:0] p;
        for (int c = 0; c < 3; c++) begin
            for (int h = 0; h < 2; h++) begin
                d = 19'(r3_m[c][2*h+1]) - 19'(r3_m[c][2*h]);
                p = 28'(d * signed'({1'b0, r3_fg})) + 28'sd64;
                n_n[c][h] = r3_m[c][2*h] + 18'(p >>> 7);
            end
        end
    end

    logic               r4_vld;
    logic signed [17:0] r4_n [3][2];
    lt3d_pkg::t_frac    r4_fb;
    logic [7:0]         r4_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= r3_vld;
        end
        if (en) begin
            r4_n     <= n_n;
            r4_fb    <= r3_fb;
            r4_alpha <= r3_alpha;
        end
    end

    // stage 5: lerp along blue, clamp
    logic [7:0] n_out [3];

    always_comb begin
        logic signed [18:0] d;
        logic signed [27:0] p;
        logic signed [18:0] s;
        logic signed [18:0] v;
        for (int c = 0; c < 3; c++) begin
            d = 19'(r4_n[c][1]) - 19'(r4_n[c][0]);
            p = 28'(d * signed'({1'b0, r4_fb})) + 28'sd128;
            s = 19'(r4_n[c][0]) + 19'sd64;
            v = (s >>> 7) + 19'(p >>> 14);
            if (v < 0) begin
                n_out[c] = 8'd0;
            end else if (v > 19'sd255) begin
                n_out[c] = 8'd255;
            end else begin
                n_out[c] = v[7:0];
            end
        end
    end

    logic r_ovld;
    logic [lt3d_pkg::OUT_DBITS-1:0] r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= r4_vld;
        end
        if (en) begin
            r_odata <= {r4_alpha, n_out[2], n_out[1], n_out[0]};
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;

    a_wr_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en |=> (r2_vld == $past(r1_vld && (r1_func == lt3d_pkg::FUNC_FILTER))))
        else $error("load request leaked into pixel pipeline");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable({r1_vld, r2_vld, r3_vld, r4_vld}))
        else $error("pipeline moved during stall");

    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r4_vld) |=> (m_axis_tdata[31:24] == $past(r4_alpha)))
        else $error("alpha not passed through");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && !r4_vld) |=> !m_axis_tvalid)
        else $error("result without pixel request");

endmodule
